/* rtl/mmps_pkg.sv */
// Shared types and constants of the mirrored Mandelbrot pixel shader.
package mmps_pkg;

    localparam logic [63:0] SQRT_HALF_Q62 = 64'd3260954456333195553;

    localparam logic [1:0] REG_ZOOM   = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_MAXIT  = 2'd2;

    localparam logic [1:0] CLS_AXIS = 2'd0;
    localparam logic [1:0] CLS_DIAG = 2'd1;
    localparam logic [1:0] CLS_ESC  = 2'd2;

    typedef struct packed {
        logic signed [18:0] qa;
        logic signed [18:0] qb;
        logic               diag;
        logic               rot_minus;
        logic               last;
    } t_job;

    function automatic logic [7:0] sat8(input logic [14:0] v);
        sat8 = (v > 15'd255) ? 8'd255 : v[7:0];
    endfunction

endpackage

/* rtl/mmps_pix_if.sv */
// Pixel coordinate channel.
interface mmps_pix_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] x_coord;
    logic signed [17:0] y_coord;
    modport source (output valid, x_coord, y_coord, input ready);
    modport sink (input valid, x_coord, y_coord, output ready);
endinterface

/* rtl/mmps_res_if.sv */
// Pixel color result channel.
interface mmps_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] pixel_class;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, pixel_class, red, green, blue, input ready);
    modport sink (input valid, pixel_class, red, green, blue, output ready);
endinterface

/* rtl/mmps_cfg_if.sv */
// Configuration register write channel.
interface mmps_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [18:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/mmps_front.sv */
// Front end: accepts a pixel word and issues its eight seed jobs.
module mmps_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mmps_pix_if.sink           i_pix,
    input  logic               i_full,
    output logic               o_push,
    output mmps_pkg::t_job     o_job
);
    logic               r_busy;
    logic [2:0]         r_idx;
    logic signed [17:0] r_x;
    logic signed [17:0] r_y;
    logic signed [18:0] w_x;
    logic signed [18:0] w_y;

    assign i_pix.ready = !r_busy;
    assign o_push = r_busy && !i_full;
    assign w_x = 19'(r_x);
    assign w_y = 19'(r_y);

    always_comb begin
        case (r_idx[1:0])
            2'd0: begin
                o_job.qa = w_x;
                o_job.qb = w_y;
            end
            2'd1: begin
                o_job.qa = -w_x;
                o_job.qb = w_y;
            end
            2'd2: begin
                o_job.qa = w_y;
                o_job.qb = w_x;
            end
            default: begin
                o_job.qa = -w_y;
                o_job.qb = w_x;
            end
        endcase
        o_job.diag = r_idx[2];
        o_job.rot_minus = (r_idx[1:0] == 2'd0) || (r_idx[1:0] == 2'd3);
        o_job.last = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= 3'd0;
        end else if (!r_busy) begin
            if (i_pix.valid) begin
                r_busy <= 1'b1;
                r_idx <= 3'd0;
                r_x <= i_pix.x_coord;
                r_y <= i_pix.y_coord;
            end
        end else if (!i_full) begin
            r_idx <= r_idx + 3'd1;
            if (r_idx == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

/* rtl/mmps_queue.sv */
// Short job queue between the front end and the orbit engine.
module mmps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mmps_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mmps_pkg::t_job o_job
);
    mmps_pkg::t_job r_mem [4];
    logic [1:0]     r_wp;
    logic [1:0]     r_rp;
    logic [2:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_job = r_mem[r_rp];
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp <= 2'd0;
            r_rp <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            case ({w_push, w_pop})
                2'b10: r_cnt <= r_cnt + 3'd1;
                2'b01: r_cnt <= r_cnt - 3'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

/* rtl/mmps_mul.sv */
// Digit-serial fixed-point multiplier with truncation toward zero.
module mmps_mul #(
    parameter int FRAC_BITS = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [FRAC_BITS+19:0]  i_a,
    input  logic signed [FRAC_BITS+19:0]  i_b,
    output logic                          o_done,
    output logic signed [FRAC_BITS+19:0]  o_res
);
    localparam int VW = FRAC_BITS + 20;
    localparam int MW = FRAC_BITS + 9;
    localparam int DW = 16;
    localparam int ND = (MW + DW - 1) / DW;
    localparam int BW = ND * DW;
    localparam int PW = MW + BW;
    localparam int AW = (PW > VW + FRAC_BITS) ? PW : VW + FRAC_BITS;
    localparam int CW = $clog2(ND + 1);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [MW-1:0]     r_ua;
    logic [BW-1:0]     r_ub;
    logic              r_neg;
    logic [AW-1:0]     r_acc;
    logic signed [VW-1:0] w_abs_a;
    logic signed [VW-1:0] w_abs_b;
    logic [MW+DW-1:0]  w_prod;
    logic [AW-1:0]     w_sh;

    assign w_abs_a = i_a[VW-1] ? -i_a : i_a;
    assign w_abs_b = i_b[VW-1] ? -i_b : i_b;
    assign w_prod = r_ua * r_ub[BW-1 -: DW];
    assign w_sh = r_acc >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt <= CW'(ND);
                    r_ua <= w_abs_a[MW-1:0];
                    r_ub <= BW'(w_abs_b[MW-1:0]);
                    r_neg <= i_a[VW-1] ^ i_b[VW-1];
                    r_acc <= '0;
                end
            end else if (r_cnt != '0) begin
                r_acc <= (r_acc << DW) + AW'(w_prod);
                r_ub <= r_ub << DW;
                r_cnt <= r_cnt - CW'(1);
            end else begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
                o_res <= r_neg ? -$signed(w_sh[VW-1:0]) : $signed(w_sh[VW-1:0]);
            end
        end
    end
endmodule

/* rtl/mmps_back.sv */
// Orbit engine: forms each seed, runs its escape iteration and colors the pixel.
module mmps_back #(
    parameter int FRAC_BITS = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [18:0]                   i_zoom,
    input  logic [18:0]                   i_radius,
    input  logic [9:0]                    i_max_it,
    input  logic                          i_empty,
    input  mmps_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_mul_start,
    output logic signed [FRAC_BITS+19:0]  o_mul_a,
    output logic signed [FRAC_BITS+19:0]  o_mul_b,
    input  logic                          i_mul_done,
    input  logic signed [FRAC_BITS+19:0]  i_mul_res,
    mmps_res_if.source                    o_res
);
    localparam int VW = FRAC_BITS + 20;
    localparam int UP = FRAC_BITS - 16;
    localparam logic [63:0] KQ =
        (mmps_pkg::SQRT_HALF_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    localparam logic signed [VW-1:0] KV = $signed(VW'(KQ));

    typedef enum logic [3:0] {
        ST_IDLE, ST_R2, ST_SA, ST_SB, ST_KA, ST_KB, ST_RR, ST_II, ST_ZI, ST_DONE
    } t_state;

    t_state               r_state;
    logic                 r_wait;
    mmps_pkg::t_job       r_job;
    logic signed [VW-1:0] r_r2, r_cr, r_ci, r_u, r_v, r_zr, r_zi, r_rr, r_ii;
    logic [10:0]          r_n;
    logic                 r_inside;
    logic                 r_axis_in, r_diag_in;
    logic [12:0]          r_asum, r_dsum;
    logic                 r_ov;
    logic [1:0]           r_cls;
    logic [7:0]           r_red, r_grn, r_blu;

    logic signed [VW-1:0] w_z1, w_z2, w_zm, w_rad, w_qa, w_qb;
    logic signed [VW:0]   w_mag;
    logic                 w_ins;
    logic [12:0]          n_asum, n_dsum;
    logic                 n_axis_in, n_diag_in;
    logic [10:0]          w_a, w_d;
    logic                 w_slot;
    logic                 w_load;

    assign w_z1 = VW'({1'b0, i_zoom}) <<< UP;
    assign w_z2 = w_z1 <<< 1;
    assign w_zm = r_job.diag ? w_z2 : w_z1;
    assign w_rad = VW'({1'b0, i_radius}) <<< UP;
    assign w_qa = VW'(r_job.qa) <<< UP;
    assign w_qb = VW'(r_job.qb) <<< UP;
    assign w_mag = (VW+1)'(r_rr) + (VW+1)'(i_mul_res);
    assign w_ins = w_mag <= (VW+1)'(r_r2);
    assign o_pop = (r_state == ST_IDLE) && !i_empty;
    assign o_mul_start = !r_wait && (r_state != ST_IDLE) && (r_state != ST_DONE);

    assign n_asum = r_asum + (r_job.diag ? 13'd0 : 13'(r_n));
    assign n_dsum = r_dsum + (r_job.diag ? 13'(r_n) : 13'd0);
    assign n_axis_in = r_axis_in || (!r_job.diag && r_inside);
    assign n_diag_in = r_diag_in || (r_job.diag && r_inside);
    assign w_a = n_asum[12:2];
    assign w_d = n_dsum[12:2];
    assign w_slot = !r_ov || o_res.ready;
    assign w_load = (r_state == ST_DONE) && r_job.last && w_slot;

    assign o_res.valid = r_ov;
    assign o_res.pixel_class = r_cls;
    assign o_res.red = r_red;
    assign o_res.green = r_grn;
    assign o_res.blue = r_blu;

    always_comb begin
        case (r_state)
            ST_R2: begin
                o_mul_a = w_rad;
                o_mul_b = w_rad;
            end
            ST_SA: begin
                o_mul_a = w_zm;
                o_mul_b = w_qa;
            end
            ST_SB: begin
                o_mul_a = w_zm;
                o_mul_b = w_qb;
            end
            ST_KA: begin
                o_mul_a = r_job.rot_minus ? r_u + r_v : r_u - r_v;
                o_mul_b = KV;
            end
            ST_KB: begin
                o_mul_a = r_job.rot_minus ? r_v - r_u : r_u + r_v;
                o_mul_b = KV;
            end
            ST_RR: begin
                o_mul_a = r_zr;
                o_mul_b = r_zr;
            end
            ST_II: begin
                o_mul_a = r_zi;
                o_mul_b = r_zi;
            end
            ST_ZI: begin
                o_mul_a = r_zr <<< 1;
                o_mul_b = r_zi;
            end
            default: begin
                o_mul_a = '0;
                o_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait <= 1'b0;
            r_axis_in <= 1'b0;
            r_diag_in <= 1'b0;
            r_asum <= '0;
            r_dsum <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (o_mul_start) begin
                r_wait <= 1'b1;
            end else if (i_mul_done) begin
                r_wait <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        r_state <= ST_R2;
                    end
                end
                ST_R2: begin
                    if (i_mul_done) begin
                        r_r2 <= i_mul_res;
                        r_state <= ST_SA;
                    end
                end
                ST_SA: begin
                    if (i_mul_done) begin
                        r_u <= i_mul_res;
                        r_cr <= i_mul_res - w_z1;
                        r_state <= ST_SB;
                    end
                end
                ST_SB: begin
                    if (i_mul_done) begin
                        r_v <= i_mul_res;
                        r_ci <= i_mul_res;
                        r_zr <= '0;
                        r_zi <= '0;
                        r_n <= '0;
                        r_state <= r_job.diag ? ST_KA : ST_RR;
                    end
                end
                ST_KA: begin
                    if (i_mul_done) begin
                        r_cr <= i_mul_res - w_z2;
                        r_state <= ST_KB;
                    end
                end
                ST_KB: begin
                    if (i_mul_done) begin
                        r_ci <= i_mul_res;
                        r_state <= ST_RR;
                    end
                end
                ST_RR: begin
                    if (i_mul_done) begin
                        r_rr <= i_mul_res;
                        r_state <= ST_II;
                    end
                end
                ST_II: begin
                    if (i_mul_done) begin
                        r_ii <= i_mul_res;
                        r_n <= r_n + 11'd1;
                        r_inside <= w_ins;
                        r_state <= w_ins ? ST_ZI : ST_DONE;
                    end
                end
                ST_ZI: begin
                    if (i_mul_done) begin
                        r_zi <= i_mul_res + r_ci;
                        r_zr <= r_rr - r_ii + r_cr;
                        r_state <= (r_n <= {1'b0, i_max_it}) ? ST_RR : ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_job.last) begin
                        r_asum <= n_asum;
                        r_dsum <= n_dsum;
                        r_axis_in <= n_axis_in;
                        r_diag_in <= n_diag_in;
                        r_state <= ST_IDLE;
                    end else if (w_slot) begin
                        r_asum <= '0;
                        r_dsum <= '0;
                        r_axis_in <= 1'b0;
                        r_diag_in <= 1'b0;
                        if (n_axis_in) begin
                            r_cls <= mmps_pkg::CLS_AXIS;
                            r_red <= 8'd0;
                            r_grn <= 8'd0;
                            r_blu <= 8'd0;
                        end else if (n_diag_in) begin
                            r_cls <= mmps_pkg::CLS_DIAG;
                            r_red <= 8'd255;
                            r_grn <= 8'd255;
                            r_blu <= 8'd255;
                        end else begin
                            r_cls <= mmps_pkg::CLS_ESC;
                            r_red <= mmps_pkg::sat8({3'b0, w_a, 1'b0} + {1'b0, w_d, 3'b0});
                            r_grn <= mmps_pkg::sat8(15'(({1'b0, w_a} + {1'b0, w_d}) >> 1));
                            r_blu <= mmps_pkg::sat8({2'b0, w_a, 2'b0} + 15'(w_d >> 1));
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_idle_no_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_wait)
        else $error("Multiplier in flight while engine is idle.");
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_done |-> r_wait)
        else $error("Product returned with no request outstanding.");
    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_cls != 2'd3))
        else $error("Illegal pixel class in result word.");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_R2))
        else $error("Popped job was not started.");
endmodule

/* rtl/mirrored_mandelbrot_pixel_shader.sv */
// Top level of the mirrored Mandelbrot pixel shader with its configuration registers.
// All products run on the one shared multiplier, in ND = ceil((FRAC_BITS+9)/16) digits of 16 bits.
// A seed costs 3 setup products (5 for a diagonal seed), 3 per pass and 2 for an escaping pass.
// Pixels are processed one after another; a new pixel word is taken once the last one's jobs
// are queued. Reset loads zoom 1.5, radius 2.0 and limit 255 and empties the queue.
module mirrored_mandelbrot_pixel_shader #(
    parameter int FRAC_BITS = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mmps_pix_if.sink    i_pix,
    mmps_cfg_if.sink    i_cfg,
    mmps_res_if.source  o_res
);
    localparam int VW = FRAC_BITS + 20;

    logic [18:0]          r_zoom;
    logic [18:0]          r_radius;
    logic [9:0]           r_max_it;
    logic                 w_push, w_full, w_pop, w_empty;
    mmps_pkg::t_job       w_fjob, w_qjob;
    logic                 w_start, w_done;
    logic signed [VW-1:0] w_a, w_b, w_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom <= 19'd98304;
            r_radius <= 19'd131072;
            r_max_it <= 10'd255;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mmps_pkg::REG_ZOOM: r_zoom <= i_cfg.data;
                mmps_pkg::REG_RADIUS: r_radius <= i_cfg.data;
                mmps_pkg::REG_MAXIT: r_max_it <= i_cfg.data[9:0];
                default: r_zoom <= r_zoom;
            endcase
        end
    end

    mmps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(i_pix),
        .i_full(w_full), .o_push(w_push), .o_job(w_fjob)
    );

    mmps_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_fjob),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_job(w_qjob)
    );

    mmps_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_a(w_a), .i_b(w_b),
        .o_done(w_done), .o_res(w_res)
    );

    mmps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_zoom(r_zoom), .i_radius(r_radius),
        .i_max_it(r_max_it), .i_empty(w_empty), .i_job(w_qjob), .o_pop(w_pop),
        .o_mul_start(w_start), .o_mul_a(w_a), .o_mul_b(w_b),
        .i_mul_done(w_done), .i_mul_res(w_res), .o_res(o_res)
    );
endmodule
